// File: design/nrte_pkg.sv
package nrte_pkg;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;

    // Sentence geometry
    localparam int DEF_MAX_SENTENCE_LEN = 120;
    localparam int CNT_W      = 7;
    localparam int PREFIX_LEN = 6;
    localparam int FIELD_LEN  = 6;
    localparam int VAL_W      = 7;

    // Comma numbers of the fields we keep
    localparam logic [3:0] COMMA_TIME   = 4'd1;
    localparam logic [3:0] COMMA_STATUS = 4'd2;
    localparam logic [3:0] COMMA_DATE   = 4'd9;
    localparam logic [3:0] COMMA_MAX    = 4'd15;
    localparam logic [2:0] OFFSET_MAX   = 3'd7;

    typedef logic [7:0] t_char;
    typedef t_char [FIELD_LEN-1:0] t_field;

    // Expected "$GPRMC" character at a given position
    function automatic t_char prefix_char(input logic [2:0] idx);
        t_char c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input t_char c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // atoi-style read of two characters
    function automatic logic [VAL_W-1:0] two_digit(input t_char c0, input t_char c1);
        logic [3:0]       d0;
        logic [3:0]       d1;
        logic [VAL_W-1:0] v;
        d0 = 4'(c0 - CH_ZERO);
        d1 = 4'(c1 - CH_ZERO);
        v  = '0;
        case (c0) inside
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_PLUS: begin
                if (is_digit(c1)) v = VAL_W'(d1);
            end
            default: begin
                if (is_digit(c0)) begin
                    if (is_digit(c1)) v = VAL_W'(d0) * VAL_W'(10) + VAL_W'(d1);
                    else              v = VAL_W'(d0);
                end
            end
        endcase
        return v;
    endfunction

endpackage

// File: design/nmea_rmc_time_extractor_unit.sv
// NMEA RMC time extractor.
// Input channel: one received ASCII character per beat on i_rx_byte
// (i_valid / o_ready). Output channel: one beat per matched $GPRMC
// sentence, on its carriage return, carrying hour, minute, second, day,
// month, year and fix_valid (o_valid / i_ready).
// A byte is held in an input register, then parsed combinationally
// against the running sentence state; a result lands in the output
// register. A carriage return passes through the input register and
// then the output register before o_valid rises. Throughput is one byte
// per cycle while no result is stalled at the output.
// When the receiver stalls, bytes that end no sentence keep flowing;
// a carriage return that would produce a second result waits in the
// input register, and o_ready drops until the pending result is taken.
// Reset (synchronous, active low) empties both registers and returns the
// parser to "no sentence started"; no clearing pass is needed.
module nmea_rmc_time_extractor_unit
    import nrte_pkg::*;
#(
    parameter int MAX_SENTENCE_LEN = DEF_MAX_SENTENCE_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_rx_byte,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [VAL_W-1:0] o_hour,
    output logic [VAL_W-1:0] o_minute,
    output logic [VAL_W-1:0] o_second,
    output logic [VAL_W-1:0] o_day,
    output logic [VAL_W-1:0] o_month,
    output logic [VAL_W-1:0] o_year,
    output logic             o_fix_valid
);

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_SENTENCE_LEN);

    // Input register
    logic       r_in_valid;
    t_char      r_in_byte;

    // Parser state
    logic             r_in_sentence, n_in_sentence;
    logic [CNT_W-1:0] r_char_count,  n_char_count;
    logic             r_prefix,      n_prefix;
    logic [3:0]       r_comma,       n_comma;
    logic [2:0]       r_offset,      n_offset;
    t_field           r_time,        n_time;
    t_field           r_date,        n_date;
    logic             r_status,      n_status;

    // Output register
    logic             r_out_valid;
    logic [VAL_W-1:0] r_hour, r_minute, r_second, r_day, r_month, r_year;
    logic             r_fix;

    logic             n_emit;
    logic             c_active;
    logic [CNT_W-1:0] c_pos;
    logic [3:0]       c_comma;
    logic [2:0]       c_offset;
    logic             c_prefix;
    logic             advance;

    // Parse one byte against the sentence state
    always_comb begin
        n_in_sentence = r_in_sentence;
        n_char_count  = r_char_count;
        n_prefix      = r_prefix;
        n_comma       = r_comma;
        n_offset      = r_offset;
        n_time        = r_time;
        n_date        = r_date;
        n_status      = r_status;
        n_emit        = 1'b0;
        c_active      = 1'b0;
        c_pos         = r_char_count;
        c_comma       = r_comma;
        c_offset      = r_offset;
        c_prefix      = r_prefix;

        if (r_in_byte == CH_DOLLAR) begin
            // start of a sentence clears everything
            n_in_sentence = 1'b1;
            c_active      = 1'b1;
            c_pos         = '0;
            c_comma       = '0;
            c_offset      = '0;
            c_prefix      = 1'b1;
            n_time        = '0;
            n_date        = '0;
            n_status      = 1'b0;
        end else if (!r_in_sentence) begin
            c_active = 1'b0;
        end else if (r_char_count >= MAX_LEN) begin
            // overlong: drop it
            n_in_sentence = 1'b0;
        end else begin
            c_active = 1'b1;
        end

        if (c_active) begin
            n_char_count = c_pos + CNT_W'(1);
            n_comma      = c_comma;
            n_offset     = c_offset;
            n_prefix     = c_prefix;
            if ((c_pos < CNT_W'(PREFIX_LEN)) && (r_in_byte != prefix_char(c_pos[2:0])))
                n_prefix = 1'b0;

            if (r_in_byte == CH_CR) begin
                n_in_sentence = 1'b0;
                n_emit        = n_prefix && (c_pos >= CNT_W'(PREFIX_LEN));
            end else if (r_in_byte == CH_COMMA) begin
                if (c_comma < COMMA_MAX) n_comma = c_comma + 4'd1;
                n_offset = '0;
                if (n_comma == COMMA_STATUS) n_status = 1'b0;
            end else begin
                if (c_comma == COMMA_TIME && c_offset < 3'(FIELD_LEN))
                    n_time[c_offset] = r_in_byte;
                else if (c_comma == COMMA_STATUS && c_offset == '0)
                    n_status = (r_in_byte == CH_A);
                else if (c_comma == COMMA_DATE && c_offset < 3'(FIELD_LEN))
                    n_date[c_offset] = r_in_byte;
                if (c_offset < OFFSET_MAX) n_offset = c_offset + 3'd1;
            end
        end
    end

    // Handshake
    assign advance = r_in_valid && (!n_emit || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (i_valid && o_ready) r_in_byte <= i_rx_byte;
    end

    // Parser state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_char_count  <= '0;
            r_prefix      <= 1'b0;
            r_comma       <= '0;
            r_offset      <= '0;
            r_time        <= '0;
            r_date        <= '0;
            r_status      <= 1'b0;
        end else if (advance) begin
            r_in_sentence <= n_in_sentence;
            r_char_count  <= n_char_count;
            r_prefix      <= n_prefix;
            r_comma       <= n_comma;
            r_offset      <= n_offset;
            r_time        <= n_time;
            r_date        <= n_date;
            r_status      <= n_status;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_emit) begin
            r_hour   <= two_digit(r_time[0], r_time[1]);
            r_minute <= two_digit(r_time[2], r_time[3]);
            r_second <= two_digit(r_time[4], r_time[5]);
            r_day    <= two_digit(r_date[0], r_date[1]);
            r_month  <= two_digit(r_date[2], r_date[3]);
            r_year   <= two_digit(r_date[4], r_date[5]);
            r_fix    <= r_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hour      = r_hour;
    assign o_minute    = r_minute;
    assign o_second    = r_second;
    assign o_day       = r_day;
    assign o_month     = r_month;
    assign o_year      = r_year;
    assign o_fix_valid = r_fix;

endmodule

// File: design/nrte_checker.sv
module nrte_checker
    import nrte_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [VAL_W-1:0] o_hour,
    input logic [VAL_W-1:0] o_minute,
    input logic [VAL_W-1:0] o_second,
    input logic [VAL_W-1:0] o_day,
    input logic [VAL_W-1:0] o_month,
    input logic [VAL_W-1:0] o_year,
    input logic             o_fix_valid
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // Input backpressure only while a result is stuck
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("o_ready low without a stalled result");

    // Every value is a two-digit number
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour <= 7'd99 && o_minute <= 7'd99 && o_second <= 7'd99 &&
                     o_day <= 7'd99 && o_month <= 7'd99 && o_year <= 7'd99))
        else $error("result value above 99");

    // Stalled result beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("o_valid dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> ($stable(o_hour) && $stable(o_minute) &&
                                   $stable(o_second) && $stable(o_day) &&
                                   $stable(o_month) && $stable(o_year) &&
                                   $stable(o_fix_valid)))
        else $error("result changed while stalled");

endmodule

bind nmea_rmc_time_extractor_unit nrte_checker u_nrte_checker (.*);

// File: tb/nmea_rmc_time_extractor_unit_test.sv
`timescale 1ns / 1ps

module nmea_rmc_time_extractor_unit_test;
    import nrte_pkg::*;

    // One decoded RMC result, laid out in port order
    typedef struct packed {
        logic [VAL_W-1:0] hour;
        logic [VAL_W-1:0] minute;
        logic [VAL_W-1:0] second;
        logic [VAL_W-1:0] day;
        logic [VAL_W-1:0] month;
        logic [VAL_W-1:0] year;
        logic             fix_valid;
    } rmc_fix_t;

    localparam int MAX_LEN = DEF_MAX_SENTENCE_LEN;
    // "$GPRMC"
    localparam logic [7:0] RMC_TAG [PREFIX_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_V     = 8'h56;

    // Sentence tracker: follows the byte stream and holds the fixes still owed
    class rmc_fix_tracker;
        rmc_fix_t         expected_fixes[$];
        int               mismatches;
        int               parsed_bytes;
        int               fix_count;
        bit               in_sentence;
        logic [CNT_W-1:0] char_count;
        bit               prefix_ok;
        logic [3:0]       comma_count;
        logic [2:0]       field_offset;
        logic [7:0]       time_chars[FIELD_LEN];
        logic [7:0]       date_chars[FIELD_LEN];
        bit               status_ok;

        function new();
            mismatches   = 0;
            parsed_bytes = 0;
            fix_count    = 0;
            in_sentence  = 1'b0;
            clear_sentence();
        endfunction

        function void clear_sentence();
            char_count   = '0;
            prefix_ok    = 1'b1;
            comma_count  = '0;
            field_offset = '0;
            status_ok    = 1'b0;
            foreach (time_chars[k]) time_chars[k] = 8'h00;
            foreach (date_chars[k]) date_chars[k] = 8'h00;
        endfunction

        // atoi on two characters; anything that is not a digit ends the number
        function logic [VAL_W-1:0] digit_pair_value(logic [7:0] c0, logic [7:0] c1);
            bit d0;
            bit d1;
            int v;
            d0 = (c0 >= CH_ZERO) && (c0 <= CH_NINE);
            d1 = (c1 >= CH_ZERO) && (c1 <= CH_NINE);
            v  = 0;
            if (c0 inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_PLUS}) begin
                if (d1) v = int'(c1) - int'(CH_ZERO);
            end else if (d0) begin
                v = int'(c0) - int'(CH_ZERO);
                if (d1) v = v * 10 + int'(c1) - int'(CH_ZERO);
            end
            return VAL_W'(v);
        endfunction

        // Accepted input beat
        function void note_byte(logic [7:0] c);
            logic [CNT_W-1:0] pos;
            rmc_fix_t         fix;
            if (c == CH_DOLLAR) begin
                clear_sentence();
                in_sentence = 1'b1;
            end else if (!in_sentence) begin
                return;
            end else if (char_count >= MAX_LEN) begin
                // overlong: drop the sentence, wait for the next '$'
                in_sentence = 1'b0;
                return;
            end
            parsed_bytes++;
            pos        = char_count;
            char_count = char_count + 1'b1;
            if (pos < PREFIX_LEN && c != RMC_TAG[pos]) prefix_ok = 1'b0;

            if (c == CH_CR) begin
                in_sentence = 1'b0;
                if (prefix_ok && pos >= PREFIX_LEN) begin
                    fix.hour      = digit_pair_value(time_chars[0], time_chars[1]);
                    fix.minute    = digit_pair_value(time_chars[2], time_chars[3]);
                    fix.second    = digit_pair_value(time_chars[4], time_chars[5]);
                    fix.day       = digit_pair_value(date_chars[0], date_chars[1]);
                    fix.month     = digit_pair_value(date_chars[2], date_chars[3]);
                    fix.year      = digit_pair_value(date_chars[4], date_chars[5]);
                    fix.fix_valid = status_ok;
                    expected_fixes.push_back(fix);
                    fix_count++;
                end
                return;
            end

            if (c == CH_COMMA) begin
                if (comma_count != COMMA_MAX) comma_count++;
                field_offset = '0;
                if (comma_count == COMMA_STATUS) status_ok = 1'b0;
                return;
            end

            if (comma_count == COMMA_TIME && field_offset < FIELD_LEN)
                time_chars[field_offset] = c;
            else if (comma_count == COMMA_STATUS && field_offset == 0)
                status_ok = (c == CH_A);
            else if (comma_count == COMMA_DATE && field_offset < FIELD_LEN)
                date_chars[field_offset] = c;
            if (field_offset != OFFSET_MAX) field_offset++;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        // Accepted output beat
        task check_fix(rmc_fix_t got);
            rmc_fix_t want;
            if (expected_fixes.size() == 0) begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            want = expected_fixes.pop_front();
            compare_field("hour",      got.hour,      want.hour);
            compare_field("minute",    got.minute,    want.minute);
            compare_field("second",    got.second,    want.second);
            compare_field("day",       got.day,       want.day);
            compare_field("month",     got.month,     want.month);
            compare_field("year",      got.year,      want.year);
            compare_field("fix_valid", got.fix_valid, want.fix_valid);
        endtask
    endclass

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             i_valid   = 1'b0;
    logic [7:0]       i_rx_byte = 8'h00;
    logic             i_ready   = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [VAL_W-1:0] o_hour;
    logic [VAL_W-1:0] o_minute;
    logic [VAL_W-1:0] o_second;
    logic [VAL_W-1:0] o_day;
    logic [VAL_W-1:0] o_month;
    logic [VAL_W-1:0] o_year;
    logic             o_fix_valid;

    rmc_fix_tracker tracker;
    logic [7:0]     tx_line[$];
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    bit             hold_off       = 1'b0;

    nmea_rmc_time_extractor_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hour      (o_hour),
        .o_minute    (o_minute),
        .o_second    (o_second),
        .o_day       (o_day),
        .o_month     (o_month),
        .o_year      (o_year),
        .o_fix_valid (o_fix_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random back-pressure, plus the long hold-off
    always @(negedge i_clk) begin
        i_ready = !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_fix({o_hour, o_minute, o_second, o_day, o_month, o_year,
                               o_fix_valid});
        end
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("nmea_rmc_time_extractor_unit_test failed");
        $finish;
    end

    // One input beat; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_byte(b);
        @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        tx_line.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) tx_line.push_back(s[k]);
    endtask

    task automatic send_line();
        foreach (tx_line[k]) send_byte(tx_line[k]);
        tx_line.delete();
    endtask

    task automatic send_sentence(input string body);
        push_text(body);
        push_byte(CH_CR);
        send_line();
    endtask

    task automatic hold_receiver(input int cycles);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // Field content: mostly digits, some atoi lead-ins, some arbitrary bytes
    function automatic logic [7:0] field_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 85) return 8'(int'(CH_ZERO) + $urandom_range(9));
        if (r < 93) begin
            case ($urandom_range(3))
                0:       return CH_SPACE;
                1:       return CH_PLUS;
                2:       return CH_MINUS;
                default: return CH_TAB;
            endcase
        end
        c = 8'($urandom_range(255));
        if (c inside {CH_DOLLAR, CH_COMMA, CH_CR}) c = CH_ZERO;
        return c;
    endfunction

    // hhmmss / ddmmyy, sometimes short, long or with a fraction
    task automatic push_clock_field();
        if ($urandom_range(4) != 0) begin
            repeat (6) push_byte(field_char());
            if ($urandom_range(1) != 0) push_text(".00");
        end else begin
            repeat ($urandom_range(0, 9)) push_byte(field_char());
        end
    endtask

    task automatic push_rmc_sentence();
        int sel;
        push_text("$GPRMC,");
        push_clock_field();
        push_byte(CH_COMMA);
        sel = $urandom_range(99);
        if (sel < 60)      push_byte(CH_A);
        else if (sel < 80) push_byte(CH_V);
        else if (sel > 89) push_byte(field_char());
        if ($urandom_range(9) == 0) push_byte(field_char());
        // fields 3 to 8
        repeat (6) begin
            push_byte(CH_COMMA);
            repeat ($urandom_range(0, 2)) push_byte(field_char());
        end
        push_byte(CH_COMMA);
        push_clock_field();
        repeat ($urandom_range(0, 3)) begin
            push_byte(CH_COMMA);
            repeat ($urandom_range(0, 2)) push_byte(field_char());
        end
        if ($urandom_range(19) == 0) repeat (8) push_byte(CH_COMMA);
        push_byte(CH_CR);
    endtask

    // Mostly well-formed sentences; the rest noise and broken ones
    task automatic push_random_traffic();
        int sel;
        int cut;
        sel = $urandom_range(99);
        if (sel < 8) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
        end else if (sel == 99) begin
            push_text("$GPRMC,");
            repeat ($urandom_range(110, 118)) push_byte(field_char());
            push_byte(CH_CR);
        end else begin
            push_rmc_sentence();
            if (sel >= 88 && sel < 94) begin
                // corrupt one prefix character
                tx_line[$urandom_range(1, PREFIX_LEN - 1)] = 8'($urandom_range(255));
            end else if (sel >= 94 && sel < 97) begin
                // early carriage return
                cut = $urandom_range(1, tx_line.size() - 1);
                while (tx_line.size() > cut) void'(tx_line.pop_back());
                push_byte(CH_CR);
            end else if (sel >= 97) begin
                // no terminator, next '$' restarts
                void'(tx_line.pop_back());
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int bytes_at_start;
        int fixes_at_start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        bytes_at_start = tracker.parsed_bytes;
        fixes_at_start = tracker.fix_count;
        while (tracker.parsed_bytes - bytes_at_start < 100 ||
               tracker.fix_count - fixes_at_start < 2) begin
            push_random_traffic();
            send_line();
        end
    endtask

    task automatic run_directed();
        // full sentence, late-in-range values
        send_sentence("$GPRMC,235959.00,A,4807.038,N,01131.000,E,022.4,084.4,311299,003.1,W*6A");
        send_sentence("$GPRMC,000000,V,,,,,,,010100,,");
        send_sentence("$GPRMC,999999,A,,,,,,,999999");
        // atoi lead-ins: space, plus, minus, tab
        send_sentence("$GPRMC, 1+2-3,A,,,,,,,\t5 6+7");
        // short fields, empty status
        send_sentence("$GPRMC,12,,,,,,,,3");
        // no date comma at all
        send_sentence("$GPRMC,123456,A,x");
        // bare prefix gives an all-zero result
        send_sentence("$GPRMC");
        // status taken from its first character only
        send_sentence("$GPRMC,010203,AV,,,,,,,040506");
        send_sentence("$GPRMC,010203,VA,,,,,,,040506");
        send_sentence("$GPRMC,010203,a,,,,,,,040506");
        // wrong talker, early carriage return
        send_sentence("$GPGGA,123456,A,,,,,,,010203");
        send_sentence("$GPR");
        // bytes outside a sentence are ignored
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(CH_CR);
        push_text("abc,9");
        send_line();
        // '$' restarts mid-sentence
        send_sentence("$GPRMC,1111$GPRMC,222222,A,,,,,,,030405");
        // long time field and saturating comma count
        send_sentence("$GPRMC,12345678901234,A,,,,,,,070809,,,,,,,,,,,,,,,,,,,,,,");
        // longest sentence that still completes
        push_text("$GPRMC,");
        repeat (MAX_LEN - 8) push_byte(8'h35);
        push_byte(CH_CR);
        send_line();
        // one byte too many: dropped, and the tail is ignored
        push_text("$GPRMC,");
        repeat (MAX_LEN - 7) push_byte(8'h31);
        push_byte(CH_CR);
        push_text("1,2");
        push_byte(CH_CR);
        send_line();
    endtask

    initial begin
        int drain_cycles;
        tracker = new();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_phase(0, 0);
        run_phase(64, 0);
        run_phase(0, 64);
        run_phase(30, 30);

        // Receiver holds off while short sentences keep coming, so the input stalls
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            hold_receiver(300);
            repeat (4) send_sentence("$GPRMC,123456,A,,,,,,,250624");
        join
        run_phase(30, 30);
        i_valid = 1'b0;

        // Drain
        drain_cycles = 0;
        while (tracker.expected_fixes.size() != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (tracker.expected_fixes.size() != 0)
            tracker.report_mismatch($sformatf("%0d expected results never arrived",
                                              tracker.expected_fixes.size()));

        if (tracker.mismatches == 0) begin
            $display("nmea_rmc_time_extractor_unit_test passed");
        end else begin
            $display("nmea_rmc_time_extractor_unit_test failed");
        end
        $finish;
    end

endmodule
